// File: rtl/icaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_pkg
// shared types, constants and the cordic arctangent table for the filter
// ----------------------------------------------------------------------------
package icaf_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_WEIGHT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_WEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ERROR_GAIN = 2'd2;

    localparam logic [15:0] ONE_G       = 16'd4096;
    localparam logic [15:0] WEIGHT_ONE  = 16'd32768;
    localparam int unsigned ATAN_LEN    = 24;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] roll_rate;
        logic signed [15:0] pitch_rate;
        logic        [15:0] interval;
        logic               roll_zero;   // ay and az both zero
        logic               pitch_zero;  // whole vector zero
    } t_item;

    typedef struct packed {
        logic [15:0] min_weight;
        logic [15:0] max_weight;
        logic [11:0] error_gain;
    } t_cfg;

    typedef struct packed {
        logic       item_valid;
        logic [1:0] level;
    } t_front_status;

    // atan(2^-i) in 16.16 degrees
    function automatic logic signed [31:0] f_atan(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117305;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/imu_complementary_attitude_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_unit
// roll and pitch complementary filter with cordic tilt angles
// ----------------------------------------------------------------------------
// Usage:
//   input channel i_valid/o_ready carries one imu sample per transfer; the
//   front queue holds up to two samples, so the sender is stalled only when
//   both entries are taken
//   output channel o_valid/i_ready returns one result per sample, in order,
//   from an output register; a stalled receiver holds the result and the
//   sequencer waits with the next result finished behind it
//   configuration writes go through i_cfg_valid/o_cfg_ready (always ready)
//   and must only be issued while the block is idle
// Sequencing:
//   each sample runs through the sequencer before the next is taken: three
//   squares on the shared multiplier, the square root digits of the 16-bit
//   root, one cordic iteration a cycle, and multiplier work for gyro,
//   weight, blend and confidence
// Reset:
//   synchronous active-low; clears the queue, the estimates and restores the
//   weight clamps and gain to their defaults
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_unit #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    input  logic signed [15:0]   i_roll_rate,
    input  logic signed [15:0]   i_pitch_rate,
    input  logic        [15:0]   i_interval,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_roll_angle,
    output logic signed [31:0]   o_pitch_angle,
    output logic        [15:0]   o_accel_magnitude,
    output logic        [6:0]    o_confidence,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [icaf_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic        [15:0]   i_cfg_data
);

    icaf_pkg::t_cfg          r_cfg;
    icaf_pkg::t_item         w_item;
    icaf_pkg::t_front_status w_status;
    logic                    w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_weight <= 16'd3277;
            r_cfg.max_weight <= 16'd31457;
            r_cfg.error_gain <= 12'd512;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                icaf_pkg::CFG_MIN_WEIGHT: r_cfg.min_weight <= i_cfg_data;
                icaf_pkg::CFG_MAX_WEIGHT: r_cfg.max_weight <= i_cfg_data;
                icaf_pkg::CFG_ERROR_GAIN: r_cfg.error_gain <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    icaf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_roll_rate  (i_roll_rate),
        .i_pitch_rate (i_pitch_rate),
        .i_interval   (i_interval),
        .i_pop        (w_pop),
        .o_item       (w_item),
        .o_status     (w_status)
    );

    icaf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (w_item),
        .i_status          (w_status),
        .o_pop             (w_pop),
        .i_cfg             (r_cfg),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_roll_angle      (o_roll_angle),
        .o_pitch_angle     (o_pitch_angle),
        .o_accel_magnitude (o_accel_magnitude),
        .o_confidence      (o_confidence)
    );

    // the confidence can never exceed a full weight
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_confidence <= 7'd100)
        else $error("confidence above 100");

    // a saturated queue is the only reason to refuse a sample
    a_ready_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> w_status.level == 2'd2)
        else $error("input stalled with queue space");

    // the queue never reports more than its two entries
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.level != 2'd3)
        else $error("queue overflow");

    // the largest representable vector length is below 56756
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_accel_magnitude <= 16'd56755)
        else $error("magnitude out of range");

endmodule

// File: rtl/icaf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_front
// accepts samples, flags zero vectors and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module icaf_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_accel_x,
    input  logic signed [15:0]      i_accel_y,
    input  logic signed [15:0]      i_accel_z,
    input  logic signed [15:0]      i_roll_rate,
    input  logic signed [15:0]      i_pitch_rate,
    input  logic        [15:0]      i_interval,
    input  logic                    i_pop,
    output icaf_pkg::t_item         o_item,
    output icaf_pkg::t_front_status o_status
);

    icaf_pkg::t_item r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_level;
    icaf_pkg::t_item w_new;
    logic       w_push, w_pop;

    always_comb begin
        w_new.accel_x    = i_accel_x;
        w_new.accel_y    = i_accel_y;
        w_new.accel_z    = i_accel_z;
        w_new.roll_rate  = i_roll_rate;
        w_new.pitch_rate = i_pitch_rate;
        w_new.interval   = i_interval;
        w_new.roll_zero  = (i_accel_y == 16'sd0) && (i_accel_z == 16'sd0);
        w_new.pitch_zero = w_new.roll_zero && (i_accel_x == 16'sd0);
    end

    assign o_ready = (r_level != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_level != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_level <= r_level + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_item              = r_q[r_rp];
    assign o_status.item_valid = (r_level != 2'd0);
    assign o_status.level      = r_level;

endmodule

// File: rtl/icaf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icaf_back
// sequencer: squares, square roots, cordic, gyro update, weight, confidence and blend
// ----------------------------------------------------------------------------
module icaf_back #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  icaf_pkg::t_item         i_item,
    input  icaf_pkg::t_front_status i_status,
    output logic                    o_pop,
    input  icaf_pkg::t_cfg          i_cfg,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [31:0]      o_roll_angle,
    output logic signed [31:0]      o_pitch_angle,
    output logic        [15:0]      o_accel_magnitude,
    output logic        [6:0]       o_confidence
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_SQZ   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_CINIT = 4'd5;
    localparam logic [3:0] S_CORD  = 4'd6;
    localparam logic [3:0] S_GYR   = 4'd7;
    localparam logic [3:0] S_GYP   = 4'd8;
    localparam logic [3:0] S_WERR  = 4'd9;
    localparam logic [3:0] S_BR1   = 4'd10;
    localparam logic [3:0] S_BR2   = 4'd11;
    localparam logic [3:0] S_BP1   = 4'd12;
    localparam logic [3:0] S_BP2   = 4'd13;
    localparam logic [3:0] S_CONF  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
    } t_cvec;

    logic [3:0] r_state;
    logic [4:0] r_cnt;
    icaf_pkg::t_item r_it;

    logic [31:0] r_sum_all, r_sum_yz;
    logic [31:0] r_rad_a, r_rad_b;
    logic [17:0] r_rem_a, r_rem_b;
    logic [15:0] r_root_a, r_root_b;
    t_cvec       r_cr, r_cp;
    logic signed [31:0] r_roll, r_pitch;
    logic [15:0] r_w;
    logic signed [50:0] r_bacc;
    logic [6:0]  r_conf;

    logic               r_out_valid;
    logic signed [31:0] r_out_roll, r_out_pitch;
    logic [15:0]        r_out_mag;
    logic [6:0]         r_out_conf;

    logic signed [32:0] w_ma;
    logic signed [17:0] w_mb;
    logic signed [50:0] w_prod;
    logic [15:0]        w_err;
    logic signed [17:0] w_wc;
    logic signed [17:0] w_w;

    function automatic t_cvec f_cord(input t_cvec v, input logic [4:0] i);
        t_cvec o;
        logic signed [33:0] dx, dy;
        dx = v.x >>> i;
        dy = v.y >>> i;
        if (!v.y[33]) begin
            o.x = v.x + dy;
            o.y = v.y - dx;
            o.z = v.z + icaf_pkg::f_atan(i);
        end else begin
            o.x = v.x - dy;
            o.y = v.y + dx;
            o.z = v.z - icaf_pkg::f_atan(i);
        end
        return o;
    endfunction

    function automatic t_cvec f_prerot(input logic signed [33:0] x,
                                       input logic signed [33:0] y);
        t_cvec o;
        o.x = x;
        o.y = y;
        o.z = 32'sd0;
        if (x[33]) begin
            if (!y[33]) begin
                o.x = y;
                o.y = -x;
                o.z = 32'sd5898240;
            end else begin
                o.x = -y;
                o.y = x;
                o.z = -32'sd5898240;
            end
        end
        return o;
    endfunction

    // one restoring square root digit
    function automatic logic [65:0] f_sqstep(input logic [31:0] rad,
                                             input logic [17:0] rem,
                                             input logic [15:0] root);
        logic [17:0] rt, tr;
        logic [15:0] nr;
        rt = {rem[15:0], rad[31:30]};
        tr = {root, 2'b01};
        if (rt >= tr) begin
            rt = rt - tr;
            nr = {root[14:0], 1'b1};
        end else begin
            nr = {root[14:0], 1'b0};
        end
        return {rad[29:0], 2'b00, rt, nr};
    endfunction

    assign w_err = (r_root_a >= icaf_pkg::ONE_G) ? (r_root_a - icaf_pkg::ONE_G)
                                                 : (icaf_pkg::ONE_G - r_root_a);
    assign w_w   = $signed({2'b00, r_w});
    assign w_wc  = $signed({2'b00, icaf_pkg::WEIGHT_ONE}) - w_w;

    // shared multiplier
    always_comb begin
        w_ma = 33'sd0;
        w_mb = 18'sd0;
        case (r_state)
            S_SQX: begin
                w_ma = 33'(r_it.accel_x);
                w_mb = 18'(r_it.accel_x);
            end
            S_SQY: begin
                w_ma = 33'(r_it.accel_y);
                w_mb = 18'(r_it.accel_y);
            end
            S_SQZ: begin
                w_ma = 33'(r_it.accel_z);
                w_mb = 18'(r_it.accel_z);
            end
            S_GYR: begin
                w_ma = 33'(r_it.roll_rate);
                w_mb = $signed({2'b00, r_it.interval});
            end
            S_GYP: begin
                w_ma = 33'(r_it.pitch_rate);
                w_mb = $signed({2'b00, r_it.interval});
            end
            S_WERR: begin
                w_ma = $signed({17'd0, w_err});
                w_mb = $signed({6'd0, i_cfg.error_gain});
            end
            S_BR1: begin
                w_ma = 33'(r_roll);
                w_mb = w_wc;
            end
            S_BR2: begin
                w_ma = r_it.roll_zero ? 33'sd0 : 33'(r_cr.z);
                w_mb = w_w;
            end
            S_BP1: begin
                w_ma = 33'(r_pitch);
                w_mb = w_wc;
            end
            S_BP2: begin
                w_ma = r_it.pitch_zero ? 33'sd0 : 33'(r_cp.z);
                w_mb = w_w;
            end
            S_CONF: begin
                w_ma = $signed({17'd0, r_w});
                w_mb = 18'sd100;
            end
            default: begin
                w_ma = 33'sd0;
                w_mb = 18'sd0;
            end
        endcase
    end
    assign w_prod = 51'(w_ma) * 51'(w_mb);

    logic signed [50:0] w_inc_full;
    logic signed [33:0] w_gsum;
    logic signed [31:0] w_gsat;
    logic signed [31:0] w_gbase;
    logic signed [25:0] w_wraw;
    logic [15:0]        w_wclamp;
    logic signed [50:0] w_bsum;
    logic [65:0]        w_sqa, w_sqb;

    assign w_sqa = f_sqstep(r_rad_a, r_rem_a, r_root_a);
    assign w_sqb = f_sqstep(r_rad_b, r_rem_b, r_root_b);

    always_comb begin
        w_gbase    = (r_state == S_GYR) ? r_roll : r_pitch;
        w_inc_full = (w_prod + 51'sd128) >>> 8;
        w_gsum     = 34'(w_gbase) + w_inc_full[33:0];
        if (w_gsum > 34'sh07FFFFFFF) begin
            w_gsat = 32'sh7FFFFFFF;
        end else if (w_gsum < -34'sh080000000) begin
            w_gsat = -32'sh80000000;
        end else begin
            w_gsat = w_gsum[31:0];
        end
        w_wraw = 26'sd32768 - $signed({3'd0, 23'((w_prod[27:0] + 28'd16) >> 5)});
        if (w_wraw < $signed({10'd0, i_cfg.min_weight})) begin
            w_wclamp = i_cfg.min_weight;
        end else if (w_wraw > $signed({10'd0, i_cfg.max_weight})) begin
            w_wclamp = i_cfg.max_weight;
        end else begin
            w_wclamp = w_wraw[15:0];
        end
        if (w_wclamp > icaf_pkg::WEIGHT_ONE) begin
            w_wclamp = icaf_pkg::WEIGHT_ONE;
        end
        w_bsum = r_bacc + w_prod + 51'sd16384;
    end

    assign o_pop = (r_state == S_IDLE) && i_status.item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_roll      <= 32'sd0;
            r_pitch     <= 32'sd0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_status.item_valid) begin
                        r_it    <= i_item;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sum_all <= w_prod[31:0];
                    r_state   <= S_SQY;
                end
                S_SQY: begin
                    r_sum_all <= r_sum_all + w_prod[31:0];
                    r_sum_yz  <= w_prod[31:0];
                    r_state   <= S_SQZ;
                end
                S_SQZ: begin
                    r_rad_a  <= r_sum_all + w_prod[31:0];
                    r_rad_b  <= r_sum_yz + w_prod[31:0];
                    r_rem_a  <= 18'd0;
                    r_rem_b  <= 18'd0;
                    r_root_a <= 16'd0;
                    r_root_b <= 16'd0;
                    r_cnt    <= 5'd0;
                    r_state  <= S_SQRT;
                end
                S_SQRT: begin
                    {r_rad_a, r_rem_a, r_root_a} <= w_sqa;
                    {r_rad_b, r_rem_b, r_root_b} <= w_sqb;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_state <= S_CINIT;
                    end
                end
                S_CINIT: begin
                    r_cr    <= f_prerot($signed({r_it.accel_z, 14'd0}),
                                        $signed({r_it.accel_y, 14'd0}));
                    r_cp    <= f_prerot($signed({2'b00, r_root_b, 16'd0}) >>> 2,
                                        -$signed({r_it.accel_x, 14'd0}));
                    r_cnt   <= 5'd0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cr  <= f_cord(r_cr, r_cnt);
                    r_cp  <= f_cord(r_cp, r_cnt);
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == LastStep) begin
                        r_state <= S_GYR;
                    end
                end
                S_GYR: begin
                    r_roll  <= w_gsat;
                    r_state <= S_GYP;
                end
                S_GYP: begin
                    r_pitch <= w_gsat;
                    r_state <= S_WERR;
                end
                S_WERR: begin
                    r_w     <= w_wclamp;
                    r_state <= S_BR1;
                end
                S_BR1: begin
                    r_bacc  <= w_prod;
                    r_state <= S_BR2;
                end
                S_BR2: begin
                    r_roll  <= w_bsum[46:15];
                    r_state <= S_BP1;
                end
                S_BP1: begin
                    r_bacc  <= w_prod;
                    r_state <= S_BP2;
                end
                S_BP2: begin
                    r_pitch <= w_bsum[46:15];
                    r_state <= S_CONF;
                end
                S_CONF: begin
                    r_conf  <= 7'((w_prod[21:0] + 22'd16384) >> 15);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= r_pitch;
            r_out_mag   <= r_root_a;
            r_out_conf  <= r_conf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_roll_angle      = r_out_roll;
    assign o_pitch_angle     = r_out_pitch;
    assign o_accel_magnitude = r_out_mag;
    assign o_confidence      = r_out_conf;

endmodule
